[design/lli_pkg.sv]
package lli_pkg;

    // Table geometry and fixed-point format.
    localparam int TABLE_ADDR_BITS = 10;
    localparam int FRAC_BITS       = 16;

    localparam int NUM_TABLES   = 4;
    localparam int SEL_BITS     = 2;
    localparam int CFG_BITS     = 5;
    localparam int DATA_BITS    = 32;
    localparam int INDEX_BITS   = 10;
    localparam int SHIFT_BITS   = $clog2(FRAC_BITS + 1);
    localparam int MEM_ADDR_BITS = TABLE_ADDR_BITS + SEL_BITS;
    localparam int PROD_BITS    = DATA_BITS + FRAC_BITS + 1;

    localparam logic [DATA_BITS-1:0] TABLE_SIZE = DATA_BITS'(1) << TABLE_ADDR_BITS;
    localparam logic [DATA_BITS-1:0] HALF_ONE   = DATA_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [0:0] {
        REQ_WRITE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_kind_t;

    typedef enum logic [SEL_BITS-1:0] {
        FUNC_EXP  = 2'd0,
        FUNC_LOG  = 2'd1,
        FUNC_SQRT = 2'd2,
        FUNC_CNDF = 2'd3
    } func_t;

    typedef struct packed {
        req_kind_t                     req_type;
        func_t                         func_sel;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [DATA_BITS-1:0]   entry_value;
        logic signed [DATA_BITS-1:0]   arg_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0]   func_result;
        logic                          range_error;
    } rsp_t;

endpackage

[design/lut_linear_interpolator.sv]
// Channel   Handshake                Payload     Meaning
// req       req_valid / req_ready    req_data    table write or function evaluation
// rsp       rsp_valid / rsp_ready    rsp_data    one result per request
// cfg       cfg_we                   cfg_index,  step exponent of one table
//                                    cfg_wdata
//
// One request is accepted per cycle while no result waits on rsp_ready; each
// result passes through registered stages in order: request capture, decode,
// the table memory read, the difference, the multiplier and the final add.
// A result that waits on rsp_ready freezes all stages together, so req_ready drops.
// Reset clears the valid bits and the step exponents; table contents are
// undefined until written and get no clearing pass.
module lut_linear_interpolator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lli_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output lli_pkg::rsp_t                       rsp_data,
    input  logic                                cfg_we,
    input  logic [lli_pkg::SEL_BITS-1:0]        cfg_index,
    input  logic [lli_pkg::CFG_BITS-1:0]        cfg_wdata
);
    import lli_pkg::*;

    logic advance;

    logic signed [CFG_BITS-1:0] step_exp_reg [NUM_TABLES];

    // Stage 1: captured request and the table's shift amount.
    logic                   s1_valid_reg;
    req_t                   s1_req_reg;
    logic [SHIFT_BITS-1:0]  s1_shift_reg;
    logic [SHIFT_BITS-1:0]  s1_shift_next;

    // Stage 2: decoded address, fraction and flags.
    logic                        s2_valid_reg;
    logic                        s2_eval_reg;
    logic                        s2_err_reg;
    logic                        s2_mirror_reg;
    logic                        s2_wr_reg;
    func_t                       s2_sel_reg;
    logic [TABLE_ADDR_BITS-1:0]  s2_addr_reg;
    logic [TABLE_ADDR_BITS-1:0]  s2_wr_idx_reg;
    logic [DATA_BITS-1:0]        s2_wr_val_reg;
    logic [FRAC_BITS-1:0]        s2_frac_reg;
    logic                        s2_mirror_next;
    logic                        s2_err_next;
    logic                        s2_wr_next;
    logic [DATA_BITS-1:0]        s2_mag;
    logic [DATA_BITS-1:0]        s2_addr_full;
    logic [DATA_BITS-1:0]        s2_frac_full;
    logic [SHIFT_BITS-1:0]       s2_lshift;

    // Stage 3: table entries.
    logic [DATA_BITS-1:0]  table_mem [NUM_TABLES * (2 ** TABLE_ADDR_BITS)];
    logic [MEM_ADDR_BITS-1:0] rd_addr_lo;
    logic [MEM_ADDR_BITS-1:0] rd_addr_hi;
    logic [MEM_ADDR_BITS-1:0] wr_addr;
    logic                  s3_valid_reg;
    logic                  s3_eval_reg;
    logic                  s3_err_reg;
    logic                  s3_mirror_reg;
    logic [FRAC_BITS-1:0]  s3_frac_reg;
    logic [DATA_BITS-1:0]  s3_base_reg;
    logic [DATA_BITS-1:0]  s3_next_reg;

    // Stage 4: neighbor difference.
    logic                        s4_valid_reg;
    logic                        s4_eval_reg;
    logic                        s4_err_reg;
    logic                        s4_mirror_reg;
    logic [FRAC_BITS-1:0]        s4_frac_reg;
    logic [DATA_BITS-1:0]        s4_base_reg;
    logic signed [DATA_BITS-1:0] s4_diff_reg;

    // Stage 5: scaled difference.
    logic                        s5_valid_reg;
    logic                        s5_eval_reg;
    logic                        s5_err_reg;
    logic                        s5_mirror_reg;
    logic [DATA_BITS-1:0]        s5_base_reg;
    logic signed [PROD_BITS-1:0] s5_prod_reg;
    logic signed [PROD_BITS-1:0] s5_prod_next;

    // Stage 6: result register.
    logic                  s6_valid_reg;
    rsp_t                  s6_rsp_reg;
    rsp_t                  s6_rsp_next;
    logic [DATA_BITS-1:0]  s6_adj;
    logic [DATA_BITS-1:0]  s6_sum;

    // The whole pipeline moves together unless a finished result is held.
    assign advance   = !s6_valid_reg || rsp_ready;
    assign req_ready = advance;
    assign rsp_valid = s6_valid_reg;
    assign rsp_data  = s6_rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                step_exp_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            step_exp_reg[cfg_index] <= signed'(cfg_wdata);
        end
    end

    // Saturate the exponent to [-FRAC_BITS, 0]; the shift is FRAC_BITS + e.
    always_comb
    begin
        int e_val;
        e_val = int'(step_exp_reg[req_data.func_sel]);
        if (e_val > 0)
        begin
            e_val = 0;
        end
        else if (e_val < -FRAC_BITS)
        begin
            e_val = -FRAC_BITS;
        end
        s1_shift_next = SHIFT_BITS'(FRAC_BITS + e_val);
    end

    always_comb
    begin
        logic [DATA_BITS-1:0] x_u;
        x_u = DATA_BITS'(s1_req_reg.arg_value);
        // Zero and negative arguments of cndf use the mirrored magnitude.
        s2_mirror_next = (s1_req_reg.func_sel == FUNC_CNDF)
                         && ((x_u == '0) || x_u[DATA_BITS-1]);
        s2_mag         = s2_mirror_next ? (DATA_BITS'(0) - x_u) : x_u;
        s2_addr_full   = s2_mag >> s1_shift_reg;
        s2_lshift      = SHIFT_BITS'(FRAC_BITS) - s1_shift_reg;
        s2_frac_full   = (s2_mag & ((DATA_BITS'(1) << s1_shift_reg) - DATA_BITS'(1)))
                         << s2_lshift;
        s2_err_next    = (s1_req_reg.req_type == REQ_EVAL)
                         && (((s1_req_reg.func_sel != FUNC_CNDF) && x_u[DATA_BITS-1])
                             || (s2_addr_full >= TABLE_SIZE - DATA_BITS'(1)));
        s2_wr_next     = (s1_req_reg.req_type == REQ_WRITE)
                         && (DATA_BITS'(s1_req_reg.entry_index) < TABLE_SIZE);
    end

    assign rd_addr_lo = {s2_sel_reg, s2_addr_reg};
    assign rd_addr_hi = {s2_sel_reg, s2_addr_reg + TABLE_ADDR_BITS'(1)};
    assign wr_addr    = {s2_sel_reg, s2_wr_idx_reg};

    // Writes and reads happen in the same stage, so program order is kept.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s2_valid_reg && s2_wr_reg)
            begin
                table_mem[wr_addr] <= s2_wr_val_reg;
            end
            s3_base_reg <= table_mem[rd_addr_lo];
            s3_next_reg <= table_mem[rd_addr_hi];
        end
    end

    assign s5_prod_next = s4_diff_reg * signed'({1'b0, s4_frac_reg});

    always_comb
    begin
        s6_adj = s5_prod_reg[FRAC_BITS +: DATA_BITS];
        if (s5_mirror_reg)
        begin
            s6_sum = HALF_ONE - s5_base_reg - s6_adj;
        end
        else
        begin
            s6_sum = s5_base_reg + s6_adj;
        end
        s6_rsp_next.range_error = s5_err_reg;
        s6_rsp_next.func_result = (s5_eval_reg && !s5_err_reg) ? signed'(s6_sum) : '0;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_req_reg    <= req_data;
            s1_shift_reg  <= s1_shift_next;

            s2_eval_reg   <= (s1_req_reg.req_type == REQ_EVAL);
            s2_err_reg    <= s2_err_next;
            s2_mirror_reg <= s2_mirror_next;
            s2_wr_reg     <= s2_wr_next;
            s2_sel_reg    <= s1_req_reg.func_sel;
            s2_addr_reg   <= TABLE_ADDR_BITS'(s2_addr_full);
            s2_wr_idx_reg <= TABLE_ADDR_BITS'(s1_req_reg.entry_index);
            s2_wr_val_reg <= DATA_BITS'(s1_req_reg.entry_value);
            s2_frac_reg   <= FRAC_BITS'(s2_frac_full);

            s3_eval_reg   <= s2_eval_reg;
            s3_err_reg    <= s2_err_reg;
            s3_mirror_reg <= s2_mirror_reg;
            s3_frac_reg   <= s2_frac_reg;

            s4_eval_reg   <= s3_eval_reg;
            s4_err_reg    <= s3_err_reg;
            s4_mirror_reg <= s3_mirror_reg;
            s4_frac_reg   <= s3_frac_reg;
            s4_base_reg   <= s3_base_reg;
            s4_diff_reg   <= signed'(s3_next_reg - s3_base_reg);

            s5_eval_reg   <= s4_eval_reg;
            s5_err_reg    <= s4_err_reg;
            s5_mirror_reg <= s4_mirror_reg;
            s5_base_reg   <= s4_base_reg;
            s5_prod_reg   <= s5_prod_next;

            s6_rsp_reg    <= s6_rsp_next;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.range_error |-> rsp_data.func_result == '0)
        else $error("range error reported with a nonzero result");

    a_write_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_eval_reg |-> !s3_err_reg)
        else $error("table write carries a range error");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> s1_valid_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s3_base_reg) && $stable(s5_prod_reg) && $stable(s2_valid_reg))
        else $error("pipeline changed during a stall");

endmodule
